// ===== rtl/transfinite_grid_interpolator_defines.svh =====
// ----------------------------------------------------------------------------
// transfinite grid interpolator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TRANSFINITE_GRID_INTERPOLATOR_DEFINES_SVH
`define TRANSFINITE_GRID_INTERPOLATOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TGI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgi checker: property failed");

// consequent checked in the cycle after the antecedent
`define TGI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgi checker: property failed");

`endif

// ===== rtl/tgi_pkg.sv =====
// ----------------------------------------------------------------------------
// tgi_pkg
// shared types, constants and register map of the transfinite grid interpolator
// ----------------------------------------------------------------------------
package tgi_pkg;

  // grid size, both powers of two so the blend denominator is a shift
  localparam int GRID_N = 32;
  localparam int GRID_M = 32;

  localparam int COORD_W = 32;
  localparam int IDX_W   = 6;
  localparam int OP_W    = 2;

  // boundary stores
  localparam int COL_DEPTH = GRID_N + 1;
  localparam int ROW_DEPTH = GRID_M + 1;
  localparam int COL_AW    = $clog2(COL_DEPTH);
  localparam int ROW_AW    = $clog2(ROW_DEPTH);
  localparam int BND_W     = 4 * COORD_W;

  // blend weights and accumulator
  localparam int I_W        = $clog2(GRID_N + 1);
  localparam int J_W        = $clog2(GRID_M + 1);
  localparam int WU_W       = I_W + J_W;
  localparam int WT_W       = WU_W + 1;
  localparam int PROD_W     = WT_W + COORD_W;
  localparam int ACC_W      = $clog2(3 * GRID_N * GRID_M) + COORD_W + 2;
  localparam int DEN_LOG2   = $clog2(GRID_N * GRID_M);
  localparam int ROUND_HALF = (2 ** DEN_LOG2) / 2;
  localparam int NUM_WTS    = 8;

  // configuration registers
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;

  localparam logic [REG_IDX_W-1:0] REG_CORNER_LO_LO_X = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CORNER_HI_LO_X = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CORNER_LO_HI_X = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_CORNER_HI_HI_X = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_CORNER_LO_LO_Y = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_CORNER_HI_LO_Y = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_CORNER_LO_HI_Y = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_CORNER_HI_HI_Y = REG_IDX_W'(7);

  typedef logic signed [COORD_W-1:0] coord_t;

  // corners -10.0, 5.0 in x and 0.0, 3.0 in y
  localparam coord_t CFG_RESET [NUM_REGS] = '{
    coord_t'(-655360), coord_t'(327680), coord_t'(-655360), coord_t'(327680),
    coord_t'(0),       coord_t'(0),      coord_t'(196608),  coord_t'(196608)
  };

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_COL = 2'd0,
    OP_LOAD_ROW = 2'd1,
    OP_QUERY    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // multiply-accumulate step: which pair of terms goes in
  typedef enum logic [1:0] {
    STEP_ROW       = 2'd0,
    STEP_COL       = 2'd1,
    STEP_CORNER_LO = 2'd2,
    STEP_CORNER_HI = 2'd3
  } step_t;

  // one store entry, first point in the low half
  typedef struct packed {
    coord_t second_y;
    coord_t second_x;
    coord_t first_y;
    coord_t first_x;
  } bnd_t;

  typedef struct packed {
    logic  capture;
    logic  store_col;
    logic  store_row;
    logic  start;
    logic  mac_en;
    step_t step;
    logic  load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic load_col;
    logic load_row;
    logic query;
  } dp_stat_t;

endpackage

// ===== rtl/tgi_ram.sv =====
// ----------------------------------------------------------------------------
// tgi_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tgi_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 33,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tgi_cfg.sv =====
// ----------------------------------------------------------------------------
// tgi_cfg
// corner registers behind the apb-style configuration port
// ----------------------------------------------------------------------------
module tgi_cfg import tgi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output coord_t             corner [NUM_REGS]
);

  coord_t                 corner_r [NUM_REGS];
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   reg_idx;

  // word addressed, byte offset bits ignored
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        corner_r[k] <= CFG_RESET[k];
      end
    end else if (wr_en) begin
      corner_r[reg_idx] <= $signed(pwdata);
    end
  end

  assign prdata = PDATA_W'(corner_r[reg_idx]);
  assign pready = 1'b1;
  assign corner = corner_r;

endmodule

// ===== rtl/tgi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgi_ctrl
// item sequencer: capture, store write or read, four mac steps, result load
// ----------------------------------------------------------------------------
module tgi_ctrl import tgi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MAC,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_ROW;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        priority if (stat.load_col) begin
          cmd.store_col = 1'b1;
        end else if (stat.load_row) begin
          cmd.store_row = 1'b1;
        end else if (stat.query) begin
          cmd.start = 1'b1;
          step_nxt  = STEP_ROW;
          state_nxt = ST_MAC;
        end else begin
          // ignored load, dropped query or unused code
          state_nxt = ST_IDLE;
        end
      end
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        if (step_r == STEP_CORNER_HI) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_t'(step_r + 2'd1);
        end
      end
      ST_DONE: begin
        // wait until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_valid_r & out_stall;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/tgi_dp.sv =====
// ----------------------------------------------------------------------------
// tgi_dp
// boundary stores, blend weights, x and y multiply-accumulate lanes, output
// ----------------------------------------------------------------------------
module tgi_dp import tgi_pkg::*; (
  input  logic             clk,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic [OP_W-1:0]  in_op,
  input  logic [IDX_W-1:0] in_col_index,
  input  logic [IDX_W-1:0] in_row_index,
  input  coord_t           in_first_x,
  input  coord_t           in_first_y,
  input  coord_t           in_second_x,
  input  coord_t           in_second_y,
  input  coord_t           corner [NUM_REGS],
  output coord_t           point_x,
  output coord_t           point_y
);

  op_t                     op_r;
  logic [IDX_W-1:0]        col_r, row_r;
  bnd_t                    ent_r;
  bnd_t                    col_q, row_q;
  logic                    col_ok, row_ok;

  logic [I_W-1:0]          i_v, ni_v;
  logic [J_W-1:0]          j_v, mj_v;
  logic [WU_W-1:0]         u_w [NUM_WTS];
  logic signed [WT_W-1:0]  w_r [NUM_WTS];
  logic signed [WT_W-1:0]  w_nxt [NUM_WTS];

  logic signed [WT_W-1:0]  wa, wb;
  coord_t                  xa, xb, ya, yb;
  logic signed [PROD_W-1:0] pxa, pxb, pya, pyb;
  logic signed [ACC_W-1:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  coord_t                  point_x_r, point_y_r;

  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'($signed(32'h7fff_ffff));
  localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'($signed(32'h8000_0000));

  // divide by GRID_N*GRID_M, round half up, clamp to 32 bits
  function automatic coord_t round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] q;
    q = (a + ACC_W'(ROUND_HALF)) >>> DEN_LOG2;
    if (q > Q_MAX) begin
      return Q_MAX[COORD_W-1:0];
    end else if (q < Q_MIN) begin
      return Q_MIN[COORD_W-1:0];
    end
    return q[COORD_W-1:0];
  endfunction

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_op);
      col_r <= in_col_index;
      row_r <= in_row_index;
      ent_r <= {in_second_y, in_second_x, in_first_y, in_first_x};
    end
  end

  assign col_ok        = int'(col_r) <= GRID_N;
  assign row_ok        = int'(row_r) <= GRID_M;
  assign stat.load_col = (op_r == OP_LOAD_COL) && col_ok;
  assign stat.load_row = (op_r == OP_LOAD_ROW) && row_ok;
  assign stat.query    = (op_r == OP_QUERY) && col_ok && row_ok;

  tgi_ram #(
    .WIDTH (BND_W),
    .DEPTH (COL_DEPTH)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (cmd.store_col),
    .wr_addr (COL_AW'(col_r)),
    .wr_data (ent_r),
    .rd_en   (cmd.start),
    .rd_addr (COL_AW'(col_r)),
    .rd_data (col_q)
  );

  tgi_ram #(
    .WIDTH (BND_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (cmd.store_row),
    .wr_addr (ROW_AW'(row_r)),
    .wr_data (ent_r),
    .rd_en   (cmd.start),
    .rd_addr (ROW_AW'(row_r)),
    .rd_data (row_q)
  );

  // weights, registered while the stores are read
  always_comb begin
    i_v  = I_W'(col_r);
    j_v  = J_W'(row_r);
    ni_v = I_W'(GRID_N) - i_v;
    mj_v = J_W'(GRID_M) - j_v;
    u_w[0] = WU_W'(ni_v) * WU_W'(GRID_M);
    u_w[1] = WU_W'(i_v)  * WU_W'(GRID_M);
    u_w[2] = WU_W'(mj_v) * WU_W'(GRID_N);
    u_w[3] = WU_W'(j_v)  * WU_W'(GRID_N);
    u_w[4] = WU_W'(ni_v) * WU_W'(mj_v);
    u_w[5] = WU_W'(i_v)  * WU_W'(mj_v);
    u_w[6] = WU_W'(ni_v) * WU_W'(j_v);
    u_w[7] = WU_W'(i_v)  * WU_W'(j_v);
    for (int k = 0; k < NUM_WTS; k++) begin
      // corner terms are subtracted
      if (k >= 4) begin
        w_nxt[k] = -$signed({1'b0, u_w[k]});
      end else begin
        w_nxt[k] = $signed({1'b0, u_w[k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      w_r <= w_nxt;
    end
  end

  // two terms per lane per step
  always_comb begin
    unique case (cmd.step)
      STEP_ROW: begin
        wa = w_r[0];            wb = w_r[1];
        xa = row_q.first_x;     xb = row_q.second_x;
        ya = row_q.first_y;     yb = row_q.second_y;
      end
      STEP_COL: begin
        wa = w_r[2];            wb = w_r[3];
        xa = col_q.first_x;     xb = col_q.second_x;
        ya = col_q.first_y;     yb = col_q.second_y;
      end
      STEP_CORNER_LO: begin
        wa = w_r[4];                     wb = w_r[5];
        xa = corner[REG_CORNER_LO_LO_X]; xb = corner[REG_CORNER_HI_LO_X];
        ya = corner[REG_CORNER_LO_LO_Y]; yb = corner[REG_CORNER_HI_LO_Y];
      end
      STEP_CORNER_HI: begin
        wa = w_r[6];                     wb = w_r[7];
        xa = corner[REG_CORNER_LO_HI_X]; xb = corner[REG_CORNER_HI_HI_X];
        ya = corner[REG_CORNER_LO_HI_Y]; yb = corner[REG_CORNER_HI_HI_Y];
      end
      default: begin
        wa = '0; wb = '0;
        xa = '0; xb = '0;
        ya = '0; yb = '0;
      end
    endcase
    pxa = wa * xa;
    pxb = wb * xb;
    pya = wa * ya;
    pyb = wb * yb;
    acc_x_nxt = acc_x_r + ACC_W'(pxa) + ACC_W'(pxb);
    acc_y_nxt = acc_y_r + ACC_W'(pya) + ACC_W'(pyb);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (cmd.mac_en) begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      point_x_r <= round_sat(acc_x_r);
      point_y_r <= round_sat(acc_y_r);
    end
  end

  assign point_x = point_x_r;
  assign point_y = point_y_r;

endmodule

// ===== rtl/transfinite_grid_interpolator.sv =====
// ----------------------------------------------------------------------------
// transfinite_grid_interpolator
// 2-d grid node generator by transfinite interpolation of boundary samples
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_op, in_col_index, in_row_index,
//                                        in_first_x/y, in_second_x/y
// out      output     out_valid/out_stall out_point_x, out_point_y
// cfg      input      psel/penable/pwrite paddr, pwdata, prdata (4 corners, x and y)
//
// a load goes through capture and store write before the block is ready again
// a query goes through capture, store read with weight setup, four
//   multiply-accumulate steps of two terms per lane, round and saturate
// the shared accumulate step sets the query time; a held result in the output
//   register keeps the query in its last cycle, in_stall high, until it moves
// reset is synchronous; the stores need no clearing pass
// ----------------------------------------------------------------------------
module transfinite_grid_interpolator import tgi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_op,
  input  logic [IDX_W-1:0]   in_col_index,
  input  logic [IDX_W-1:0]   in_row_index,
  input  logic signed [COORD_W-1:0] in_first_x,
  input  logic signed [COORD_W-1:0] in_first_y,
  input  logic signed [COORD_W-1:0] in_second_x,
  input  logic signed [COORD_W-1:0] in_second_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  coord_t   corner [NUM_REGS];

  tgi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .corner  (corner)
  );

  tgi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tgi_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .in_op        (in_op),
    .in_col_index (in_col_index),
    .in_row_index (in_row_index),
    .in_first_x   (in_first_x),
    .in_first_y   (in_first_y),
    .in_second_x  (in_second_x),
    .in_second_y  (in_second_y),
    .corner       (corner),
    .point_x      (out_point_x),
    .point_y      (out_point_y)
  );

endmodule

// ===== rtl/tgi_checker.sv =====
// ----------------------------------------------------------------------------
// tgi_checker
// port level checks of the transfinite grid interpolator, bound to the top
// ----------------------------------------------------------------------------
`include "transfinite_grid_interpolator_defines.svh"

module tgi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_point_x,
  input logic [31:0] out_point_y
);

  // a stalled result stays and holds its value
  `TGI_ASSERT_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid)
  `TGI_ASSERT_NEXT(a_out_data_hold, out_valid && out_stall, $stable(out_point_x) && $stable(out_point_y))

  // one item at a time: busy right after a transfer
  `TGI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // no result can come out of an item just taken
  `TGI_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid))

  // a new result appears exactly as the block turns ready
  `TGI_ASSERT_SAME(a_result_at_ready, $rose(out_valid), !in_stall)

endmodule

bind transfinite_grid_interpolator tgi_checker u_tgi_checker (.*);

// ===== verif/tb_transfinite_grid_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transfinite grid interpolator testbench
// loads boundary samples into both stores and queries grid nodes under random
// idling on both channels; each node is predicted from a shadow copy of the
// stores and corners and compared field by field, over several corner settings
// ----------------------------------------------------------------------------
module tb_transfinite_grid_interpolator;
  import tgi_pkg::*;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int NUM_PHASES = 5;
  localparam int SETTLE_CYCLES = 20;
  localparam int LIMIT_CYCLES = 500000;

  localparam logic [REG_IDX_W-1:0] CORNER_REGS [NUM_REGS] = '{
    REG_CORNER_LO_LO_X, REG_CORNER_HI_LO_X, REG_CORNER_LO_HI_X, REG_CORNER_HI_HI_X,
    REG_CORNER_LO_LO_Y, REG_CORNER_HI_LO_Y, REG_CORNER_LO_HI_Y, REG_CORNER_HI_HI_Y
  };

  class grid_node_scoreboard;
    typedef struct {
      coord_t x;
      coord_t y;
    } node_t;

    bnd_t   col_store [GRID_N+1];
    bnd_t   row_store [GRID_M+1];
    coord_t corner [NUM_REGS];
    node_t  pending_nodes [$];
    int     errors;

    function new();
      corner = CFG_RESET;
      errors = 0;
    endfunction

    function void set_corner(logic [REG_IDX_W-1:0] idx, coord_t val);
      corner[idx] = val;
    endfunction

    function int outstanding();
      return pending_nodes.size();
    endfunction

    // exact sum over the common denominator, round half up, saturate
    function coord_t interpolate_lane(longint i, longint j, longint lft, longint rgt,
                                      longint bot, longint top, longint c00,
                                      longint c10, longint c01, longint c11);
      longint ni, mj, num, den, q;
      ni = GRID_N - i;
      mj = GRID_M - j;
      num = ni * GRID_M * lft + i * GRID_M * rgt + mj * GRID_N * bot + j * GRID_N * top
          - ni * mj * c00 - i * mj * c10 - ni * j * c01 - i * j * c11;
      den = 2 * GRID_N * GRID_M;
      num = 2 * num + GRID_N * GRID_M;
      q = num / den;
      if (num % den != 0 && num < 0) q -= 1;
      if (q > COORD_MAX) q = COORD_MAX;
      if (q < COORD_MIN) q = COORD_MIN;
      return coord_t'(q);
    endfunction

    function void note_transfer(op_t op, logic [IDX_W-1:0] ci, logic [IDX_W-1:0] ri,
                                coord_t fx, coord_t fy, coord_t sx, coord_t sy);
      bnd_t  entry;
      bnd_t  col;
      bnd_t  row;
      node_t node;
      entry = '{second_y: sy, second_x: sx, first_y: fy, first_x: fx};
      case (op)
        OP_LOAD_COL: begin
          if (ci <= GRID_N) col_store[ci] = entry;
        end
        OP_LOAD_ROW: begin
          if (ri <= GRID_M) row_store[ri] = entry;
        end
        OP_QUERY: begin
          if (ci <= GRID_N && ri <= GRID_M) begin
            col = col_store[ci];
            row = row_store[ri];
            node.x = interpolate_lane(ci, ri, row.first_x, row.second_x, col.first_x,
                                      col.second_x, corner[REG_CORNER_LO_LO_X],
                                      corner[REG_CORNER_HI_LO_X], corner[REG_CORNER_LO_HI_X],
                                      corner[REG_CORNER_HI_HI_X]);
            node.y = interpolate_lane(ci, ri, row.first_y, row.second_y, col.first_y,
                                      col.second_y, corner[REG_CORNER_LO_LO_Y],
                                      corner[REG_CORNER_HI_LO_Y], corner[REG_CORNER_LO_HI_Y],
                                      corner[REG_CORNER_HI_HI_Y]);
            pending_nodes.push_back(node);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_point(coord_t px, coord_t py);
      node_t want;
      if (pending_nodes.size() == 0) begin
        report($sformatf("unexpected point x=%0d y=%0d", px, py));
        return;
      end
      want = pending_nodes.pop_front();
      if (px !== want.x) report($sformatf("point_x got %0d want %0d", px, want.x));
      if (py !== want.y) report($sformatf("point_y got %0d want %0d", py, want.y));
    endtask

    task close_out();
      while (pending_nodes.size() != 0) begin
        report($sformatf("node x=%0d y=%0d never arrived",
                         pending_nodes[0].x, pending_nodes[0].y));
        void'(pending_nodes.pop_front());
      end
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_op = OP_NONE;
  logic [IDX_W-1:0] in_col_index = '0;
  logic [IDX_W-1:0] in_row_index = '0;
  logic signed [COORD_W-1:0] in_first_x = '0;
  logic signed [COORD_W-1:0] in_first_y = '0;
  logic signed [COORD_W-1:0] in_second_x = '0;
  logic signed [COORD_W-1:0] in_second_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  grid_node_scoreboard nodes = new();
  int idle_pct = 31;
  int cycle_count = 0;
  bit col_written [GRID_N+1];
  bit row_written [GRID_M+1];

  transfinite_grid_interpolator uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < idle_pct);

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      nodes.note_transfer(op_t'(in_op), in_col_index, in_row_index, in_first_x,
                          in_first_y, in_second_x, in_second_y);
    if (rst_n && out_valid && !out_stall) nodes.check_point(out_point_x, out_point_y);
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return coord_t'($urandom_range(2 ** 21)) - coord_t'(2 ** 20);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // mostly in range, with the ends and the out-of-range codes weighted up
  function automatic logic [IDX_W-1:0] pick_index(int top);
    int r;
    r = $urandom_range(99);
    if (r < 8) return IDX_W'($urandom_range(2 ** IDX_W - 1, top + 1));
    if (r < 13) return '0;
    if (r < 18) return IDX_W'(top);
    return IDX_W'($urandom_range(top));
  endfunction

  task automatic send_item(op_t op, logic [IDX_W-1:0] ci, logic [IDX_W-1:0] ri,
                           coord_t fx, coord_t fy, coord_t sx, coord_t sy);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_col_index <= ci;
    in_row_index <= ri;
    in_first_x <= fx;
    in_first_y <= fy;
    in_second_x <= sx;
    in_second_y <= sy;
    do @(posedge clk); while (in_stall);
  endtask

  // tracks written entries so that no query ever reads an unwritten one
  task automatic issue(op_t op, logic [IDX_W-1:0] ci, logic [IDX_W-1:0] ri,
                       coord_t fx, coord_t fy, coord_t sx, coord_t sy);
    if (op == OP_LOAD_COL && ci <= GRID_N) col_written[ci] = 1'b1;
    if (op == OP_LOAD_ROW && ri <= GRID_M) row_written[ri] = 1'b1;
    send_item(op, ci, ri, fx, fy, sx, sy);
  endtask

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, coord_t val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    nodes.set_corner(idx, val);
  endtask

  task automatic cfg_read_check(logic [REG_IDX_W-1:0] idx, coord_t want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      nodes.report($sformatf("register %0d reads %0d want %0d", idx, prdata, want));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the last transfer reach the scoreboard and a trailing load finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (nodes.outstanding() != 0) @(posedge clk);
  endtask

  task automatic directed_items();
    issue(OP_LOAD_COL, 0, 0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    issue(OP_LOAD_COL, IDX_W'(GRID_N), 0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    issue(OP_LOAD_ROW, 0, 0, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    issue(OP_LOAD_ROW, 0, IDX_W'(GRID_M), COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    // grid corners, saturating both ways
    issue(OP_QUERY, 0, 0, 0, 0, 0, 0);
    issue(OP_QUERY, IDX_W'(GRID_N), IDX_W'(GRID_M), 0, 0, 0, 0);
    issue(OP_QUERY, 0, IDX_W'(GRID_M), 0, 0, 0, 0);
    issue(OP_QUERY, IDX_W'(GRID_N), 0, 0, 0, 0, 0);
    // half-lsb ties at the grid middle: +0.5 in x, -0.5 in y
    issue(OP_LOAD_COL, IDX_W'(GRID_N / 2), 0, 0, 0, 0, 0);
    issue(OP_LOAD_ROW, 0, IDX_W'(GRID_M / 2), 1, -1, 0, 0);
    issue(OP_QUERY, IDX_W'(GRID_N / 2), IDX_W'(GRID_M / 2), 0, 0, 0, 0);
    issue(OP_LOAD_COL, 1, 0, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    // ignored loads and the unused code must not disturb the stores
    issue(OP_LOAD_COL, IDX_W'(GRID_N + 1), 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    issue(OP_LOAD_ROW, 0, '1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    issue(OP_NONE, 1, IDX_W'(GRID_M / 2), COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    issue(OP_QUERY, 1, IDX_W'(GRID_M / 2), '1, '1, '1, '1);
    issue(OP_QUERY, IDX_W'(GRID_N + 1), 0, 0, 0, 0, 0);
    issue(OP_QUERY, 0, '1, 0, 0, 0, 0);
    issue(OP_QUERY, '1, '1, 0, 0, 0, 0);
    issue(OP_LOAD_ROW, 0, 1, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    issue(OP_QUERY, IDX_W'(GRID_N), 1, 0, 0, 0, 0);
    issue(OP_QUERY, IDX_W'(GRID_N / 2), 0, 0, 0, 0, 0);
  endtask

  task automatic random_items(int target);
    int count;
    int r;
    op_t op;
    logic [IDX_W-1:0] ci;
    logic [IDX_W-1:0] ri;
    logic [IDX_W-1:0] last_col;
    logic [IDX_W-1:0] last_row;
    bit follow;
    count = 0;
    follow = 1'b0;
    last_col = '0;
    last_row = '0;
    while (count < target) begin
      r = $urandom_range(99);
      op = (r < 4) ? OP_NONE : (r < 28) ? OP_LOAD_COL : (r < 52) ? OP_LOAD_ROW : OP_QUERY;
      ci = pick_index(GRID_N);
      ri = pick_index(GRID_M);
      // query straight after a load of the same entry
      if (follow && $urandom_range(3) == 0) begin
        op = OP_QUERY;
        ci = last_col;
        ri = last_row;
      end
      if (op == OP_QUERY && ci <= GRID_N && ri <= GRID_M) begin
        if (!col_written[ci]) op = OP_LOAD_COL;
        else if (!row_written[ri]) op = OP_LOAD_ROW;
      end
      follow = 1'b0;
      if (op == OP_LOAD_COL && ci <= GRID_N) begin
        follow = row_written[last_row];
        last_col = ci;
      end
      if (op == OP_LOAD_ROW && ri <= GRID_M) begin
        follow = col_written[last_col];
        last_row = ri;
      end
      count++;
      issue(op, ci, ri, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  function automatic coord_t corner_setting(int phase_idx);
    case (phase_idx)
      1: return COORD_MAX;
      2: return COORD_MIN;
      3: return rand_coord();
      default: return coord_t'($urandom_range(2 ** 22)) - coord_t'(2 ** 21);
    endcase
  endfunction

  initial begin
    coord_t val;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        wait_idle();
        for (int k = 0; k < NUM_REGS; k++) begin
          val = corner_setting(ph);
          cfg_write(CORNER_REGS[k], val);
          cfg_read_check(CORNER_REGS[k], val);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
      end
      idle_pct = (ph == 3) ? 0 : 31;
      if (ph == 0) directed_items();
      random_items(ITEMS_PER_PHASE);
    end
    wait_idle();
    nodes.close_out();
    if (nodes.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tgi_pkg.sv
rtl/tgi_ram.sv
rtl/tgi_cfg.sv
rtl/tgi_ctrl.sv
rtl/tgi_dp.sv
rtl/transfinite_grid_interpolator.sv
rtl/tgi_checker.sv
verif/tb_transfinite_grid_interpolator.sv
